FILE: hdl/phps_pkg.sv
// Shared types, constants and decode functions for the proximity haptic profile selector.
package phps_pkg;

	// Zone count and zone indexes
	localparam int unsigned ZONES = 3;
	localparam int unsigned ZONE_W = 2;
	localparam logic [ZONE_W-1:0] ZONE_LEFT   = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_CENTER = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_RIGHT  = 2'd2;

	// Field widths
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// Item kinds
	localparam logic FUNC_TICK     = 1'b0;
	localparam logic FUNC_OVERRIDE = 1'b1;

	// Pattern codes on the output
	localparam logic [MODE_W-1:0] MODE_NONE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CONT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_P1    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_P2    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_P4    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_P8    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_HEART = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SYS   = 3'd7;

	// Fixed intensities of the distance bands
	localparam logic [LEVEL_W-1:0] LEVEL_OFF       = 8'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_APPROACH  = 8'd38;
	localparam logic [LEVEL_W-1:0] LEVEL_NEAR      = 8'd89;
	localparam logic [LEVEL_W-1:0] LEVEL_VERY_NEAR = 8'd166;
	localparam logic [LEVEL_W-1:0] LEVEL_DANGER    = 8'd230;
	localparam logic [LEVEL_W-1:0] LEVEL_CONTACT   = 8'd255;

	// Override target codes
	localparam logic [7:0] TGT_LEFT   = 8'h01;
	localparam logic [7:0] TGT_CENTER = 8'h02;
	localparam logic [7:0] TGT_ALL    = 8'hFF;

	// Requested pattern codes
	localparam logic [7:0] PAT_CONT_A = 8'h00;
	localparam logic [7:0] PAT_HEART  = 8'h01;
	localparam logic [7:0] PAT_CONT_B = 8'h02;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_LIMIT     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APPROACH_LIMIT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERY_NEAR_LIMIT = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DANGER_LIMIT    = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OVR_DURATION    = 8'd5;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] RST_CLEAR_LIMIT     = 16'd400;
	localparam logic [CFG_DATA_W-1:0] RST_APPROACH_LIMIT  = 16'd200;
	localparam logic [CFG_DATA_W-1:0] RST_NEAR_LIMIT      = 16'd100;
	localparam logic [CFG_DATA_W-1:0] RST_VERY_NEAR_LIMIT = 16'd50;
	localparam logic [CFG_DATA_W-1:0] RST_DANGER_LIMIT    = 16'd25;
	localparam logic [CFG_DATA_W-1:0] RST_OVR_DURATION    = 16'd2000;

	typedef struct packed {
		logic               func;
		logic [TIME_W-1:0]  now_time;
		logic [DIST_W-1:0]  left_dist;
		logic [DIST_W-1:0]  center_dist;
		logic [DIST_W-1:0]  right_dist;
		logic [7:0]         target_motor;
		logic [7:0]         req_pattern;
		logic [7:0]         req_intensity;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] left_level;
		logic [MODE_W-1:0]  left_mode;
		logic [LEVEL_W-1:0] center_level;
		logic [MODE_W-1:0]  center_mode;
		logic [LEVEL_W-1:0] right_level;
		logic [MODE_W-1:0]  right_mode;
	} out_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [MODE_W-1:0]  mode;
	} profile_t;

	typedef struct packed {
		logic [DIST_W-1:0] clear_lim;
		logic [DIST_W-1:0] approach_lim;
		logic [DIST_W-1:0] near_lim;
		logic [DIST_W-1:0] very_near_lim;
		logic [DIST_W-1:0] danger_lim;
	} limits_t;

	// Per-zone strobes from the top level
	typedef struct packed {
		logic tick;  // a tick item leaves the input stage
		logic set;   // an override item for this zone leaves the input stage
	} zone_ctl_t;

	// Map a distance through the ordered thresholds
	function automatic profile_t map_distance(input logic [DIST_W-1:0] d, input limits_t lim);
		profile_t p;
		if (d > lim.clear_lim) begin
			p = '{level: LEVEL_OFF, mode: MODE_NONE};
		end else if (d >= lim.approach_lim) begin
			p = '{level: LEVEL_APPROACH, mode: MODE_P1};
		end else if (d >= lim.near_lim) begin
			p = '{level: LEVEL_NEAR, mode: MODE_P2};
		end else if (d >= lim.very_near_lim) begin
			p = '{level: LEVEL_VERY_NEAR, mode: MODE_P4};
		end else if (d >= lim.danger_lim) begin
			p = '{level: LEVEL_DANGER, mode: MODE_P8};
		end else begin
			p = '{level: LEVEL_CONTACT, mode: MODE_CONT};
		end
		return p;
	endfunction

	// Renumber a requested pattern
	function automatic logic [MODE_W-1:0] decode_pattern(input logic [7:0] pat);
		logic [MODE_W-1:0] m;
		case (pat)
			PAT_CONT_A, PAT_CONT_B: m = MODE_CONT;
			PAT_HEART:              m = MODE_HEART;
			default:                m = MODE_SYS;
		endcase
		return m;
	endfunction

	// Does an override target reach the given zone; unknown targets go right
	function automatic logic target_hits(input logic [7:0] tgt, input logic [ZONE_W-1:0] zone);
		logic hit;
		case (zone)
			ZONE_LEFT:   hit = tgt inside {TGT_LEFT, TGT_ALL};
			ZONE_CENTER: hit = tgt inside {TGT_CENTER, TGT_ALL};
			default:     hit = !(tgt inside {TGT_LEFT, TGT_CENTER});
		endcase
		return hit;
	endfunction

endpackage

FILE: hdl/phps_zone.sv
// One motor zone: override store, expiry check and profile selection.
module phps_zone (
	input  logic                               clk,
	input  logic                               arst_n,
	input  phps_pkg::zone_ctl_t                ctl,
	input  logic [phps_pkg::TIME_W-1:0]        now_time,
	input  logic [phps_pkg::DIST_W-1:0]        zone_dist,
	input  phps_pkg::limits_t                  limits,
	input  phps_pkg::profile_t                 ovr_profile,
	input  logic [phps_pkg::TIME_W-1:0]        ovr_deadline,
	output phps_pkg::profile_t                 profile
);
	import phps_pkg::*;

	logic              ovr_on_q;
	profile_t          ovr_prof_q;
	logic [TIME_W-1:0] ovr_deadline_q;
	logic              live;

	// An override is live until the time reaches its deadline
	assign live = ovr_on_q && (now_time < ovr_deadline_q);

	// Set on an override transfer, drop on a tick once expired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovr_on_q <= 1'b0;
		end else if (ctl.set) begin
			ovr_on_q <= 1'b1;
		end else if (ctl.tick && !live) begin
			ovr_on_q <= 1'b0;
		end
	end

	// Hold the override profile and its deadline
	always_ff @(posedge clk) begin
		if (ctl.set) begin
			ovr_prof_q     <= ovr_profile;
			ovr_deadline_q <= ovr_deadline;
		end
	end

	// Pick the live override, else the distance band
	assign profile = live ? ovr_prof_q : map_distance(zone_dist, limits);

endmodule

FILE: hdl/proximity_haptic_profile_selector_top.sv
// Top level of the proximity haptic profile selector.
// A tick's item is held in the input register, and its result is loaded into the result
// register when it leaves the input stage; an override item updates the zone stores and
// gives no result.
// Throughput: one item per cycle; the input stage frees whenever the result register
// is empty or being taken, so the only stall is a full result register held by the sink.
// Reset: asynchronous, clears both valid flags and all override flags and loads the
// threshold and duration registers with their defaults.
module proximity_haptic_profile_selector_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  phps_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output phps_pkg::out_item_t                  out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [phps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [phps_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import phps_pkg::*;

	logic [CFG_DATA_W-1:0] clear_limit_q;
	logic [CFG_DATA_W-1:0] approach_limit_q;
	logic [CFG_DATA_W-1:0] near_limit_q;
	logic [CFG_DATA_W-1:0] very_near_limit_q;
	logic [CFG_DATA_W-1:0] danger_limit_q;
	logic [CFG_DATA_W-1:0] ovr_duration_q;

	logic              valid_s1;
	in_item_t          item_s1;
	logic              advance;
	logic              out_valid_q;
	out_item_t         out_data_q;

	limits_t           limits;
	profile_t          ovr_profile;
	logic [TIME_W-1:0] ovr_deadline;
	logic [DIST_W-1:0] dist_z [ZONES];
	profile_t          prof_z [ZONES];
	out_item_t         result;

	// Configuration registers, always ready; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_limit_q     <= RST_CLEAR_LIMIT;
			approach_limit_q  <= RST_APPROACH_LIMIT;
			near_limit_q      <= RST_NEAR_LIMIT;
			very_near_limit_q <= RST_VERY_NEAR_LIMIT;
			danger_limit_q    <= RST_DANGER_LIMIT;
			ovr_duration_q    <= RST_OVR_DURATION;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CLEAR_LIMIT:     clear_limit_q     <= cfg_data;
				REG_APPROACH_LIMIT:  approach_limit_q  <= cfg_data;
				REG_NEAR_LIMIT:      near_limit_q      <= cfg_data;
				REG_VERY_NEAR_LIMIT: very_near_limit_q <= cfg_data;
				REG_DANGER_LIMIT:    danger_limit_q    <= cfg_data;
				REG_OVR_DURATION:    ovr_duration_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limits = '{clear_lim:     clear_limit_q,
	                  approach_lim:  approach_limit_q,
	                  near_lim:      near_limit_q,
	                  very_near_lim: very_near_limit_q,
	                  danger_lim:    danger_limit_q};

	// Advance the input stage: overrides always leave, ticks need room in the result register
	assign advance  = valid_s1 && ((item_s1.func == FUNC_OVERRIDE) || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// Override profile and deadline, shared by all zones
	assign ovr_profile  = '{level: item_s1.req_intensity,
	                        mode:  decode_pattern(item_s1.req_pattern)};
	assign ovr_deadline = item_s1.now_time + {{(TIME_W-CFG_DATA_W){1'b0}}, ovr_duration_q};

	assign dist_z[ZONE_LEFT]   = item_s1.left_dist;
	assign dist_z[ZONE_CENTER] = item_s1.center_dist;
	assign dist_z[ZONE_RIGHT]  = item_s1.right_dist;

	// Zone units
	for (genvar z = 0; z < ZONES; z++) begin : g_zone
		zone_ctl_t ctl;

		assign ctl.tick = advance && (item_s1.func == FUNC_TICK);
		assign ctl.set  = advance && (item_s1.func == FUNC_OVERRIDE)
		                  && target_hits(item_s1.target_motor, ZONE_W'(z));

		phps_zone u_zone (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.now_time     (item_s1.now_time),
			.zone_dist    (dist_z[z]),
			.limits       (limits),
			.ovr_profile  (ovr_profile),
			.ovr_deadline (ovr_deadline),
			.profile      (prof_z[z])
		);
	end

	assign result = '{left_level:   prof_z[ZONE_LEFT].level,
	                  left_mode:    prof_z[ZONE_LEFT].mode,
	                  center_level: prof_z[ZONE_CENTER].level,
	                  center_mode:  prof_z[ZONE_CENTER].mode,
	                  right_level:  prof_z[ZONE_RIGHT].level,
	                  right_mode:   prof_z[ZONE_RIGHT].mode};

	// Result register: load on a tick leaving the input stage, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && (item_s1.func == FUNC_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (item_s1.func == FUNC_TICK)) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hdl/phps_checker.sv
// Port-level checks for the proximity haptic profile selector, bound to the top level.
module phps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input phps_pkg::out_item_t             out_data,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	import phps_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// With no result waiting the block must take input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// Mode none only comes from the off band, which has zero intensity
	a_none_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.left_mode != MODE_NONE) || (out_data.left_level == LEVEL_OFF))
		&& ((out_data.center_mode != MODE_NONE) || (out_data.center_level == LEVEL_OFF))
		&& ((out_data.right_mode != MODE_NONE) || (out_data.right_level == LEVEL_OFF)))
		else $error("zone off with nonzero intensity");

	// Configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind proximity_haptic_profile_selector_top phps_checker u_phps_checker (.*);

FILE: test/proximity_haptic_profile_selector_top_test.sv
// Testbench for the proximity haptic profile selector: directed and random items checked against a zone model.
module proximity_haptic_profile_selector_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import phps_pkg::*;

	localparam int unsigned CLK_PERIOD    = 10;
	localparam int unsigned RESET_CYCLES  = 8;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned RUN_LIMIT_NS  = 3_000_000;
	localparam int unsigned REG_COUNT     = 6;
	localparam int unsigned MAX_REPORTS   = 40;
	localparam int unsigned HOLD_CYCLES   = 200;

	// Register indexes that the block must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 8'hFF;

	// Targets and patterns outside the decoded codes
	localparam logic [7:0] TGT_OTHER    = 8'h07;
	localparam logic [7:0] TGT_OTHER_LO = 8'h00;
	localparam logic [7:0] PAT_OTHER    = 8'h80;
	localparam logic [7:0] PAT_OTHER_HI = 8'hFF;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// Zone model state; the register shadow spans the full index range
	logic [CFG_DATA_W-1:0] reg_shadow    [1 << CFG_IDX_W];
	logic                  held_on       [ZONES];
	logic [LEVEL_W-1:0]    held_level    [ZONES];
	logic [MODE_W-1:0]     held_mode     [ZONES];
	logic [TIME_W-1:0]     held_deadline [ZONES];
	out_item_t             profile_q[$];

	// Traffic shaping
	int unsigned src_idle_pct   = 0;
	int unsigned sink_idle_pct  = 0;
	int unsigned sink_hold_left = 0;
	logic [TIME_W-1:0] sim_ms        = '0;
	logic [TIME_W-1:0] last_deadline = '0;

	// Run statistics
	int unsigned mismatch_count     = 0;
	int unsigned items_sent         = 0;
	int unsigned overrides_sent     = 0;
	int unsigned results_checked    = 0;
	int unsigned expiries_seen      = 0;
	int unsigned reg_writes         = 0;
	int unsigned input_stall_cycles = 0;

	proximity_haptic_profile_selector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t ns  mismatch: %s", $time, msg);
		end
	endtask

	// Band lookup through the five thresholds, first match wins
	function automatic profile_t zone_band(input logic [DIST_W-1:0] d);
		profile_t p;
		if (d > reg_shadow[REG_CLEAR_LIMIT]) begin
			p = '{level: LEVEL_OFF, mode: MODE_NONE};
		end else if (d >= reg_shadow[REG_APPROACH_LIMIT]) begin
			p = '{level: LEVEL_APPROACH, mode: MODE_P1};
		end else if (d >= reg_shadow[REG_NEAR_LIMIT]) begin
			p = '{level: LEVEL_NEAR, mode: MODE_P2};
		end else if (d >= reg_shadow[REG_VERY_NEAR_LIMIT]) begin
			p = '{level: LEVEL_VERY_NEAR, mode: MODE_P4};
		end else if (d >= reg_shadow[REG_DANGER_LIMIT]) begin
			p = '{level: LEVEL_DANGER, mode: MODE_P8};
		end else begin
			p = '{level: LEVEL_CONTACT, mode: MODE_CONT};
		end
		return p;
	endfunction

	// Update the zone stores for one accepted item and queue the profiles a tick produces
	task automatic predict_profiles(input in_item_t item);
		logic [DIST_W-1:0] zone_dist [ZONES];
		profile_t          prof [ZONES];
		logic [MODE_W-1:0] req_mode;
		logic [TIME_W-1:0] deadline;
		logic              hit;
		out_item_t         res;
		zone_dist[0] = item.left_dist;
		zone_dist[1] = item.center_dist;
		zone_dist[2] = item.right_dist;
		if (item.func == FUNC_OVERRIDE) begin
			overrides_sent++;
			deadline = item.now_time + reg_shadow[REG_OVR_DURATION];
			if (item.req_pattern == PAT_HEART) begin
				req_mode = MODE_HEART;
			end else if (item.req_pattern == PAT_CONT_A || item.req_pattern == PAT_CONT_B) begin
				req_mode = MODE_CONT;
			end else begin
				req_mode = MODE_SYS;
			end
			for (int z = 0; z < ZONES; z++) begin
				hit = (item.target_motor == TGT_ALL)
					|| (z == ZONE_LEFT && item.target_motor == TGT_LEFT)
					|| (z == ZONE_CENTER && item.target_motor == TGT_CENTER)
					|| (z == ZONE_RIGHT && item.target_motor != TGT_LEFT
						&& item.target_motor != TGT_CENTER);
				if (hit) begin
					held_on[z]       = 1'b1;
					held_level[z]    = item.req_intensity;
					held_mode[z]     = req_mode;
					held_deadline[z] = deadline;
				end
			end
		end else begin
			for (int z = 0; z < ZONES; z++) begin
				// drop an override whose deadline has passed
				if (held_on[z] && item.now_time >= held_deadline[z]) begin
					held_on[z] = 1'b0;
					expiries_seen++;
				end
				if (held_on[z]) begin
					prof[z] = '{level: held_level[z], mode: held_mode[z]};
				end else begin
					prof[z] = zone_band(zone_dist[z]);
				end
			end
			res.left_level   = prof[0].level;
			res.left_mode    = prof[0].mode;
			res.center_level = prof[1].level;
			res.center_mode  = prof[1].mode;
			res.right_level  = prof[2].level;
			res.right_mode   = prof[2].mode;
			profile_q.push_back(res);
		end
	endtask

	// Offer one item, holding valid until the transfer
	task automatic send_item(input in_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		predict_profiles(item);
	endtask

	// Stop offering, wait for every pending profile and let the pipeline settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (profile_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_COUNT) begin
			reg_shadow[idx] = value;
		end
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_limits(input logic [CFG_DATA_W-1:0] clear_lim, approach_lim, near_lim,
			very_near_lim, danger_lim);
		write_reg(REG_CLEAR_LIMIT, clear_lim);
		write_reg(REG_APPROACH_LIMIT, approach_lim);
		write_reg(REG_NEAR_LIMIT, near_lim);
		write_reg(REG_VERY_NEAR_LIMIT, very_near_lim);
		write_reg(REG_DANGER_LIMIT, danger_lim);
	endtask

	function automatic in_item_t noise_item();
		in_item_t item;
		item.func          = 1'($urandom_range(1));
		item.now_time      = 32'($urandom);
		item.left_dist     = 16'($urandom);
		item.center_dist   = 16'($urandom);
		item.right_dist    = 16'($urandom);
		item.target_motor  = 8'($urandom);
		item.req_pattern   = 8'($urandom);
		item.req_intensity = 8'($urandom);
		return item;
	endfunction

	function automatic in_item_t tick_at(input logic [TIME_W-1:0] t,
			input logic [DIST_W-1:0] l, c, r);
		in_item_t item;
		item             = noise_item();
		item.func        = FUNC_TICK;
		item.now_time    = t;
		item.left_dist   = l;
		item.center_dist = c;
		item.right_dist  = r;
		return item;
	endfunction

	function automatic in_item_t override_at(input logic [TIME_W-1:0] t,
			input logic [7:0] tgt, pat, lvl);
		in_item_t item;
		item               = noise_item();
		item.func          = FUNC_OVERRIDE;
		item.now_time      = t;
		item.target_motor  = tgt;
		item.req_pattern   = pat;
		item.req_intensity = lvl;
		return item;
	endfunction

	// Distances cluster around the thresholds so every boundary gets hit
	function automatic logic [DIST_W-1:0] pick_distance();
		logic [DIST_W-1:0] d;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: d = reg_shadow[CFG_IDX_W'($urandom_range(4))]
				+ 16'($urandom_range(4)) - 16'd2;
			6, 7:             d = 16'($urandom_range(600));
			8:                d = 16'($urandom);
			default:          d = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		endcase
		return d;
	endfunction

	// Mostly a running clock with overrides and ticks around their deadlines, some pure noise
	task automatic make_item(output in_item_t item);
		int unsigned pick;
		item = noise_item();
		pick = $urandom_range(99);
		if (pick < 8) begin
			return;
		end
		if (pick < 30) begin
			item.func     = FUNC_OVERRIDE;
			item.now_time = sim_ms;
			case ($urandom_range(3))
				0: item.target_motor = TGT_LEFT;
				1: item.target_motor = TGT_CENTER;
				2: item.target_motor = TGT_ALL;
				default: ;
			endcase
			case ($urandom_range(3))
				0: item.req_pattern = PAT_CONT_A;
				1: item.req_pattern = PAT_HEART;
				2: item.req_pattern = PAT_CONT_B;
				default: ;
			endcase
			last_deadline = sim_ms + reg_shadow[REG_OVR_DURATION];
		end else begin
			item.func = FUNC_TICK;
			if ($urandom_range(4) == 0) begin
				sim_ms = last_deadline + 32'($urandom_range(2)) - 32'd1;
			end else begin
				sim_ms = sim_ms + 32'($urandom_range(reg_shadow[REG_OVR_DURATION] / 4 + 1));
			end
			item.now_time    = sim_ms;
			item.left_dist   = pick_distance();
			item.center_dist = pick_distance();
			item.right_dist  = pick_distance();
		end
	endtask

	// Sink: random stalls, or a counted hold-off when one is requested
	always @(negedge clk) begin
		if (sink_hold_left != 0) begin
			out_ready      <= 1'b0;
			sink_hold_left <= sink_hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic check_zone(input string zone, input logic [LEVEL_W-1:0] got_level, want_level,
			input logic [MODE_W-1:0] got_mode, want_mode);
		if (got_level !== want_level) begin
			report_mismatch($sformatf("%s level got %0d want %0d", zone, got_level, want_level));
		end
		if (got_mode !== want_mode) begin
			report_mismatch($sformatf("%s mode got %0d want %0d", zone, got_mode, want_mode));
		end
	endtask

	// Compare each result transfer with the oldest pending profile
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) begin
				input_stall_cycles++;
			end
			if (out_valid && out_ready) begin
				if (profile_q.size() == 0) begin
					report_mismatch("result transfer with no tick pending");
				end else begin
					want = profile_q.pop_front();
					results_checked++;
					check_zone("left", out_data.left_level, want.left_level,
						out_data.left_mode, want.left_mode);
					check_zone("center", out_data.center_level, want.center_level,
						out_data.center_mode, want.center_mode);
					check_zone("right", out_data.right_level, want.right_level,
						out_data.right_mode, want.right_mode);
				end
			end
		end
	end

	// Every band and its boundaries at the reset thresholds
	task automatic test_distance_bands();
		send_item(tick_at(32'd1000, 16'hFFFF, 16'd401, 16'd400));
		send_item(tick_at(32'd1001, 16'd200, 16'd199, 16'd100));
		send_item(tick_at(32'd1002, 16'd99, 16'd50, 16'd49));
		send_item(tick_at(32'd1003, 16'd25, 16'd24, 16'd0));
		drain();
	endtask

	// Per-zone and all-zone overrides, pattern renumbering, expiry at the deadline
	task automatic test_override_profiles();
		send_item(override_at(32'd2000, TGT_LEFT, PAT_CONT_A, 8'h00));
		send_item(override_at(32'd2000, TGT_CENTER, PAT_HEART, 8'hFF));
		send_item(override_at(32'd2000, TGT_OTHER, PAT_CONT_B, 8'hA5));
		send_item(tick_at(32'd2001, 16'd0, 16'd0, 16'd0));
		send_item(override_at(32'd2500, TGT_ALL, PAT_OTHER, 8'h5A));
		send_item(tick_at(32'd4499, 16'd0, 16'd0, 16'd0));
		send_item(tick_at(32'd4500, 16'd300, 16'd60, 16'd30));
		send_item(override_at(32'd5000, TGT_OTHER_LO, PAT_OTHER_HI, 8'h11));
		send_item(tick_at(32'd5000, 16'd10, 16'd10, 16'd10));
		drain();
	endtask

	// Deadline past the 32-bit wrap, and a zero duration that expires at once
	task automatic test_deadline_wrap();
		write_reg(REG_OVR_DURATION, 16'hFFFF);
		send_item(override_at(32'hFFFF_FFF0, TGT_ALL, PAT_HEART, 8'h33));
		send_item(tick_at(32'hFFFF_FFFF, 16'd10, 16'd10, 16'd10));
		send_item(override_at(32'h0000_0010, TGT_LEFT, PAT_CONT_B, 8'hC3));
		send_item(tick_at(32'h0000_1000, 16'd10, 16'd10, 16'd10));
		drain();
		write_reg(REG_OVR_DURATION, 16'h0000);
		send_item(override_at(32'd100, TGT_CENTER, PAT_OTHER, 8'h7E));
		send_item(tick_at(32'd100, 16'd500, 16'd500, 16'd500));
		drain();
	endtask

	// Thresholds at both ends, out of order, and writes to indexes that do not exist
	task automatic test_limit_extremes();
		write_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_item(tick_at(32'h0002_0000, 16'd0, 16'd1, 16'hFFFF));
		drain();
		write_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(tick_at(32'h0002_0001, 16'hFFFF, 16'hFFFE, 16'd0));
		drain();
		write_limits(16'd1000, 16'd10, 16'd500, 16'd20, 16'd300);
		send_item(tick_at(32'h0002_0002, 16'd600, 16'd15, 16'd5));
		drain();
		write_reg(REG_SPARE_FIRST, 16'hFFFF);
		write_reg(REG_SPARE_LAST, 16'h0000);
		send_item(tick_at(32'h0002_0003, 16'd1001, 16'd9, 16'd400));
		drain();
	endtask

	// Load one of three register settings: tight ordered, wide ordered, or fully random
	task automatic load_random_setting(input int unsigned style);
		int unsigned step_max;
		int unsigned lim [5];
		if (style == 2) begin
			write_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
			write_reg(REG_OVR_DURATION, 16'($urandom));
		end else begin
			step_max = (style == 0) ? 60 : 4000;
			lim[4] = $urandom_range(step_max);
			for (int k = 3; k >= 0; k--) begin
				lim[k] = lim[k + 1] + $urandom_range(step_max);
			end
			write_limits(16'(lim[0]), 16'(lim[1]), 16'(lim[2]), 16'(lim[3]), 16'(lim[4]));
			if (style == 0) begin
				write_reg(REG_OVR_DURATION, 16'($urandom_range(400, 50)));
			end else begin
				write_reg(REG_OVR_DURATION, 16'($urandom_range(65535, 1000)));
			end
		end
	endtask

	task automatic test_random_traffic(input int unsigned src_pct, sink_pct, count, style);
		in_item_t item;
		load_random_setting(style);
		// the wide setting starts just short of the time wrap
		sim_ms        = (style == 1) ? 32'hFFFF_FFFF - 32'($urandom_range(30000)) : 32'($urandom);
		last_deadline = sim_ms;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (count) begin
			make_item(item);
			send_item(item);
		end
		drain();
	endtask

	// Hold the sink off long enough for the block to fill and stall its input
	task automatic test_input_backpressure();
		in_item_t item;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		@(posedge clk);
		sink_hold_left = HOLD_CYCLES;
		repeat (40) begin
			make_item(item);
			send_item(item);
		end
		drain();
	endtask

	initial begin
		reg_shadow[REG_CLEAR_LIMIT]     = RST_CLEAR_LIMIT;
		reg_shadow[REG_APPROACH_LIMIT]  = RST_APPROACH_LIMIT;
		reg_shadow[REG_NEAR_LIMIT]      = RST_NEAR_LIMIT;
		reg_shadow[REG_VERY_NEAR_LIMIT] = RST_VERY_NEAR_LIMIT;
		reg_shadow[REG_DANGER_LIMIT]    = RST_DANGER_LIMIT;
		reg_shadow[REG_OVR_DURATION]    = RST_OVR_DURATION;
		for (int z = 0; z < ZONES; z++) begin
			held_on[z]       = 1'b0;
			held_level[z]    = '0;
			held_mode[z]     = MODE_NONE;
			held_deadline[z] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_distance_bands();
		test_override_profiles();
		test_deadline_wrap();
		test_limit_extremes();
		test_random_traffic(21, 81, 460, 0);
		test_random_traffic(81, 21, 460, 1);
		test_input_backpressure();
		test_random_traffic(0, 0, 460, 2);

		$display("Sent %0d items (%0d override commands), checked %0d profile results, %0d expiries.",
			items_sent, overrides_sent, results_checked, expiries_seen);
		$display("Made %0d register writes; input held off by a full pipeline for %0d cycles.",
			reg_writes, input_stall_cycles);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#(RUN_LIMIT_NS);
		$display("run limit reached with %0d profiles pending", profile_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
hdl/phps_pkg.sv
hdl/phps_zone.sv
hdl/proximity_haptic_profile_selector_top.sv
hdl/phps_checker.sv
test/proximity_haptic_profile_selector_top_test.sv
